// ===== rtl/lslt_pkg.sv =====
package lslt_pkg;

	localparam int NUM_STYLES_DEF  = 64;
	localparam int MAX_PATTERN_DEF = 64;

	// Field widths of one input word and one result word.
	localparam int CMD_W    = 2;
	localparam int STYLE_W  = 6;
	localparam int POS_W    = 6;
	localparam int LETTER_W = 5;
	localparam int PLEN_W   = 7;
	localparam int TICK_W   = 31;
	localparam int LEVEL_W  = 10;
	localparam int MODE_W   = 2;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 16;

	// Bit offsets inside the input tdata.
	localparam int STYLE_LSB  = 0;
	localparam int POS_LSB    = STYLE_LSB + STYLE_W;
	localparam int LETTER_LSB = POS_LSB + POS_W;
	localparam int PLEN_LSB   = LETTER_LSB + LETTER_W;
	localparam int PEAK_LSB   = PLEN_LSB + PLEN_W;
	localparam int AVG_LSB    = PEAK_LSB + LETTER_W;
	localparam int TICK_LSB   = AVG_LSB + LETTER_W;

	localparam logic [LEVEL_W-1:0] UNUSED_LEVEL = 10'd256;
	localparam logic [LEVEL_W-1:0] LEVEL_STEP   = 10'd22;
	localparam logic [LEVEL_W-1:0] MAX_LEVEL    = 10'd682;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_LETTER = 2'd0,
		CMD_WRITE_HEADER = 2'd1,
		CMD_EVALUATE     = 2'd2,
		CMD_NONE         = 2'd3
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ANIMATE = 2'd0,
		MODE_AVERAGE = 2'd1,
		MODE_PEAK    = 2'd2,
		MODE_OTHER   = 2'd3
	} flat_mode_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_HDR    = 6'b000010,
		S_DIV    = 6'b000100,
		S_READ   = 6'b001000,
		S_LETTER = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	typedef struct packed {
		logic [PLEN_W-1:0]   len;
		logic [LETTER_W-1:0] peak;
		logic [LETTER_W-1:0] avg;
	} hdr_t;

endpackage

// ===== rtl/lslt_ram.sv =====
module lslt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/light_style_level_table.sv =====
// Light style level table. Load words (tuser 0: one pattern letter, tuser 1: a style header
// with length, peak and average level) are taken while the block is idle and do not occupy it. An evaluate word
// (tuser 2) returns one result word with the style and its 2.8 light scale: 256 for an
// unused style or a style beyond the table, otherwise 22 times the peak level, the average
// level or the pattern letter at tick modulo length, as flat_mode selects. A flat-mode or
// unused-style evaluate passes through the header read and the output stage (a style beyond
// the table only through the output stage); an animated evaluate passes through the header
// read, the remainder unit, which works through the tick bits one bit per cycle, the pattern
// memory read and the output stage. The result sits in an output register, so the next word
// is taken while it waits; an evaluate that finishes while the previous result still waits
// holds the block until that result is taken. Style lengths read as zero after reset through
// one valid flip-flop per style; there is no clearing pass.
module light_style_level_table #(
	parameter int NUM_STYLES  = lslt_pkg::NUM_STYLES_DEF,
	parameter int MAX_PATTERN = lslt_pkg::MAX_PATTERN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lslt_pkg::MODE_W-1:0]      cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// style, position, letter, pattern_length, peak_letter, average_letter, tick, zero pad
	input  logic [lslt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// command
	input  logic [lslt_pkg::CMD_W-1:0]       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// style_out, level_value
	output logic [lslt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	import lslt_pkg::*;

	localparam int SIDX_W  = (NUM_STYLES > 1) ? $clog2(NUM_STYLES) : 1;
	localparam int PAT_DEP = NUM_STYLES * MAX_PATTERN;
	localparam int PAW     = (PAT_DEP > 1) ? $clog2(PAT_DEP) : 1;
	localparam int CNT_W   = $clog2(TICK_W);

	state_t                state_q;
	logic [MODE_W-1:0]     flat_mode_q;
	logic [STYLE_W-1:0]    style_q;
	logic [SIDX_W-1:0]     sidx_q;
	logic [TICK_W-1:0]     tick_q;
	logic [PLEN_W-1:0]     len_q;
	logic [PLEN_W-1:0]     rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [NUM_STYLES-1:0] hdr_valid_q;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic                  acc;
	cmd_t                  cmd;
	logic [STYLE_W-1:0]    in_style;
	logic [POS_W-1:0]      in_pos;
	logic [LETTER_W-1:0]   in_letter;
	logic [PLEN_W-1:0]     in_plen;
	logic                  in_table;
	logic [SIDX_W-1:0]     in_sidx;
	logic [PLEN_W-1:0]     sat_len;

	hdr_t                  hdr_wdata;
	hdr_t                  hdr_rdata;
	logic                  hdr_we;
	logic                  hdr_re;
	logic [PLEN_W-1:0]     hdr_len;

	logic                  pat_we;
	logic [PAW-1:0]        pat_waddr;
	logic [PAW-1:0]        pat_raddr;
	logic [LETTER_W-1:0]   pat_rdata;

	logic [PLEN_W:0]       trial;
	logic [PLEN_W:0]       trial_sub;
	logic [PLEN_W-1:0]     rem_next;

	logic [LETTER_W-1:0]   mul_k;
	logic [LEVEL_W-1:0]    mul_level;
	logic                  out_free;

	assign acc       = s_axis_tvalid && s_axis_tready;
	assign cmd       = cmd_t'(s_axis_tuser);
	assign in_style  = s_axis_tdata[STYLE_LSB +: STYLE_W];
	assign in_pos    = s_axis_tdata[POS_LSB +: POS_W];
	assign in_letter = s_axis_tdata[LETTER_LSB +: LETTER_W];
	assign in_plen   = s_axis_tdata[PLEN_LSB +: PLEN_W];
	assign in_table  = 9'(in_style) < 9'(NUM_STYLES);
	assign in_sidx   = SIDX_W'(in_style);
	assign sat_len   = (9'(in_plen) > 9'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : in_plen;

	assign s_axis_tready = (state_q == S_IDLE);

	// Style headers: length, peak and average written together.
	assign hdr_wdata.len  = sat_len;
	assign hdr_wdata.peak = s_axis_tdata[PEAK_LSB +: LETTER_W];
	assign hdr_wdata.avg  = s_axis_tdata[AVG_LSB +: LETTER_W];
	assign hdr_we = acc && (cmd == CMD_WRITE_HEADER) && in_table;
	assign hdr_re = acc && (cmd == CMD_EVALUATE);

	lslt_ram #(
		.WIDTH ($bits(hdr_t)),
		.DEPTH (NUM_STYLES)
	) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (in_sidx),
		.wdata (hdr_wdata),
		.re    (hdr_re),
		.raddr (in_sidx),
		.rdata (hdr_rdata)
	);

	// A style never written since reset has length zero.
	assign hdr_len = hdr_valid_q[sidx_q] ? hdr_rdata.len : '0;

	assign pat_we    = acc && (cmd == CMD_WRITE_LETTER) && in_table &&
	                   (9'(in_pos) < 9'(MAX_PATTERN));
	assign pat_waddr = PAW'(PAW'(in_sidx) * PAW'(MAX_PATTERN)) + PAW'(in_pos);
	assign pat_raddr = PAW'(PAW'(sidx_q) * PAW'(MAX_PATTERN)) + PAW'(rem_q);

	lslt_ram #(
		.WIDTH (LETTER_W),
		.DEPTH (PAT_DEP)
	) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (in_letter),
		.re    (state_q == S_READ),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	// One restoring remainder step per cycle, tick bits taken from the top.
	assign trial     = {rem_q, tick_q[TICK_W-1]};
	assign trial_sub = trial - {1'b0, len_q};
	assign rem_next  = (trial >= {1'b0, len_q}) ? trial_sub[PLEN_W-1:0] : trial[PLEN_W-1:0];

	always_comb begin
		case (flat_mode_q)
			MODE_PEAK:    mul_k = hdr_rdata.peak;
			MODE_AVERAGE: mul_k = hdr_rdata.avg;
			default:      mul_k = hdr_rdata.avg;
		endcase
		if (state_q == S_LETTER) begin
			mul_k = pat_rdata;
		end
	end

	assign mul_level = LEVEL_W'(mul_k) * LEVEL_STEP;
	assign out_free  = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_mode_q <= MODE_ANIMATE;
		end else if (cfg_we) begin
			flat_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid_q <= '0;
		end else if (hdr_we) begin
			hdr_valid_q[in_sidx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc && (cmd == CMD_EVALUATE)) begin
						state_q <= in_table ? S_HDR : S_DONE;
					end
				end
				S_HDR: begin
					if ((hdr_len != '0) && (flat_mode_q != MODE_PEAK) &&
					    (flat_mode_q != MODE_AVERAGE)) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(TICK_W - 1)) begin
						state_q <= S_READ;
					end
				end
				S_READ:   state_q <= S_LETTER;
				S_LETTER: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			style_q <= in_style;
			sidx_q  <= in_sidx;
			tick_q  <= s_axis_tdata[TICK_LSB +: TICK_W];
			level_q <= UNUSED_LEVEL;
		end
		if (state_q == S_HDR) begin
			len_q <= hdr_len;
			rem_q <= '0;
			cnt_q <= '0;
			if (hdr_len != '0) begin
				level_q <= mul_level;
			end
		end
		if (state_q == S_DIV) begin
			rem_q  <= rem_next;
			tick_q <= {tick_q[TICK_W-2:0], 1'b0};
			cnt_q  <= cnt_q + 1'b1;
		end
		if (state_q == S_LETTER) begin
			level_q <= mul_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			m_data_q <= {level_q, style_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (cmd == CMD_EVALUATE)) |=> !s_axis_tready)
		else $error("block still ready after taking an evaluate word");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (cmd != CMD_EVALUATE) && !m_valid_q) |=> !m_valid_q)
		else $error("load word produced a result");

	a_rem_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < len_q))
		else $error("remainder not below pattern length");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:STYLE_W] <= MAX_LEVEL))
		else $error("level value out of range");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("waiting result changed");
`endif

endmodule
